// ===== hw/rtl/cfcd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcd_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the command
// frame decoder.
// ----------------------------------------------------------------------------
package cfcd_pkg;

    // Frame layout
    localparam int unsigned FRAME_LAST_POS = 9;
    localparam int unsigned CRC_SPAN       = 8;
    localparam int unsigned INDEX_W        = 4;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VERSION = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_CODE        = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_CODE       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_LIMIT      = 8'd3;

    // Register reset values
    localparam logic [7:0]  PROTOCOL_VERSION_RST = 8'd1;
    localparam logic [7:0]  STOP_CODE_RST        = 8'd0;
    localparam logic [7:0]  DRIVE_CODE_RST       = 8'd1;
    localparam logic [14:0] DRIVE_LIMIT_RST      = 15'd1000;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_BAD_LENGTH   = 3'd1,
        STATUS_BAD_VERSION  = 3'd2,
        STATUS_BAD_CRC      = 3'd3,
        STATUS_BAD_OPCODE   = 3'd4,
        STATUS_BAD_RANGE    = 3'd5,
        STATUS_BAD_SEMANTIC = 3'd6
    } status_t;

    // Configuration values seen by the checker
    typedef struct packed {
        logic [7:0]  protocol_version;
        logic [7:0]  stop_code;
        logic [7:0]  drive_code;
        logic [14:0] drive_limit;
    } cfg_t;

    // Frame state collected so far
    typedef struct packed {
        logic [INDEX_W-1:0] byte_index;
        logic [15:0]        crc_accum;
        logic               version_match;
        logic [7:0]         op_hold;
        logic [15:0]        seq_hold;
        logic [15:0]        left_hold;
        logic [15:0]        right_hold;
        logic [7:0]         crc_low_hold;
    } frame_t;

    // Byte-wide CRC update, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== hw/rtl/cfcd_capture.sv =====
// ----------------------------------------------------------------------------
// cfcd_capture
// Frame state registers: byte position, running CRC, version flag and the
// decoded field bytes. Position, CRC and version flag are cleared after the final byte of each frame.
// ----------------------------------------------------------------------------
module cfcd_capture
    import cfcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_accept,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic [7:0]  protocol_version,
    output frame_t      frame
);

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]        crc_accum_reg, crc_accum_next;
    logic               version_match_reg, version_match_next;
    logic [7:0]         op_hold_reg;
    logic [15:0]        seq_hold_reg;
    logic [15:0]        left_hold_reg;
    logic [15:0]        right_hold_reg;
    logic [7:0]         crc_low_hold_reg;

    // Advance position and CRC; drop back to the initial state on frame end
    always_comb begin
        byte_index_next    = byte_index_reg;
        crc_accum_next     = crc_accum_reg;
        version_match_next = version_match_reg;
        if (byte_accept) begin
            if (frame_end) begin
                byte_index_next    = '0;
                crc_accum_next     = CRC_INIT;
                version_match_next = 1'b0;
            end else begin
                if (byte_index_reg != INDEX_MAX) begin
                    byte_index_next = byte_index_reg + 1'b1;
                end
                if (byte_index_reg < INDEX_W'(CRC_SPAN)) begin
                    crc_accum_next = crc_byte(crc_accum_reg, frame_byte);
                end
                if (byte_index_reg == '0) begin
                    version_match_next = (frame_byte == protocol_version);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg    <= '0;
            crc_accum_reg     <= CRC_INIT;
            version_match_reg <= 1'b0;
        end else begin
            byte_index_reg    <= byte_index_next;
            crc_accum_reg     <= crc_accum_next;
            version_match_reg <= version_match_next;
        end
    end

    // Hold the field bytes at their frame positions
    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            unique case (byte_index_reg)
                4'd1:    op_hold_reg          <= frame_byte;
                4'd2:    seq_hold_reg[7:0]    <= frame_byte;
                4'd3:    seq_hold_reg[15:8]   <= frame_byte;
                4'd4:    left_hold_reg[7:0]   <= frame_byte;
                4'd5:    left_hold_reg[15:8]  <= frame_byte;
                4'd6:    right_hold_reg[7:0]  <= frame_byte;
                4'd7:    right_hold_reg[15:8] <= frame_byte;
                4'd8:    crc_low_hold_reg     <= frame_byte;
                default: ;
            endcase
        end
    end

    assign frame.byte_index    = byte_index_reg;
    assign frame.crc_accum     = crc_accum_reg;
    assign frame.version_match = version_match_reg;
    assign frame.op_hold       = op_hold_reg;
    assign frame.seq_hold      = seq_hold_reg;
    assign frame.left_hold     = left_hold_reg;
    assign frame.right_hold    = right_hold_reg;
    assign frame.crc_low_hold  = crc_low_hold_reg;

endmodule

// ===== hw/rtl/cfcd_check.sv =====
// ----------------------------------------------------------------------------
// cfcd_check
// Frame checks in priority order on the final byte, and the result register
// toward the output channel.
// ----------------------------------------------------------------------------
module cfcd_check
    import cfcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               result_load,
    input  logic [7:0]         frame_byte,
    input  frame_t             frame,
    input  cfg_t               cfg,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [2:0]         m_status,
    output logic [7:0]         m_op,
    output logic [15:0]        m_seq_number,
    output logic signed [15:0] m_left_drive,
    output logic signed [15:0] m_right_drive
);

    logic               m_valid_reg, m_valid_next;
    status_t            status_reg, status_next;
    logic [7:0]         op_reg;
    logic [15:0]        seq_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;

    logic signed [16:0] lim_pos;
    logic signed [16:0] lim_neg;
    logic signed [16:0] left_ext;
    logic signed [16:0] right_ext;
    logic               range_bad;
    logic               is_stop;
    logic               is_drive;

    // Compare the signed drive values against plus or minus the limit
    assign lim_pos   = signed'({2'b00, cfg.drive_limit});
    assign lim_neg   = -lim_pos;
    assign left_ext  = signed'({frame.left_hold[15], frame.left_hold});
    assign right_ext = signed'({frame.right_hold[15], frame.right_hold});
    assign range_bad = (left_ext < lim_neg) || (left_ext > lim_pos)
                    || (right_ext < lim_neg) || (right_ext > lim_pos);
    assign is_stop   = (frame.op_hold == cfg.stop_code);
    assign is_drive  = (frame.op_hold == cfg.drive_code);

    // Run the checks in order; the first failure sets the status
    always_comb begin
        priority if (frame.byte_index != INDEX_W'(FRAME_LAST_POS)) begin
            status_next = STATUS_BAD_LENGTH;
        end else if (!frame.version_match) begin
            status_next = STATUS_BAD_VERSION;
        end else if ({frame_byte, frame.crc_low_hold} != frame.crc_accum) begin
            status_next = STATUS_BAD_CRC;
        end else if (!is_stop && !is_drive) begin
            status_next = STATUS_BAD_OPCODE;
        end else if (range_bad) begin
            status_next = STATUS_BAD_RANGE;
        end else if (is_stop && (frame.left_hold != '0 || frame.right_hold != '0)) begin
            status_next = STATUS_BAD_SEMANTIC;
        end else begin
            status_next = STATUS_OK;
        end
    end

    // Set valid on a load, drop it once the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result; decoded fields only when the frame passed
    always_ff @(posedge aclk) begin
        if (result_load) begin
            status_reg <= status_next;
            if (status_next == STATUS_OK) begin
                op_reg    <= frame.op_hold;
                seq_reg   <= frame.seq_hold;
                left_reg  <= signed'(frame.left_hold);
                right_reg <= signed'(frame.right_hold);
            end else begin
                op_reg    <= '0;
                seq_reg   <= '0;
                left_reg  <= '0;
                right_reg <= '0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_op          = op_reg;
    assign m_seq_number  = seq_reg;
    assign m_left_drive  = left_reg;
    assign m_right_drive = right_reg;

endmodule

// ===== hw/rtl/command_frame_crc_decoder.sv =====
// ----------------------------------------------------------------------------
// command_frame_crc_decoder
// Checks and decodes 10-byte command frames protected by CRC-16/CCITT-FALSE.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_): one frame byte per transfer, s_frame_end on the last
//   byte. Output channel (m_): one result per frame, given after the transfer
//   that carries s_frame_end: status plus opcode, sequence number and the two
//   signed drive values, all zero unless the status is OK.
//   Config channel (cfg_): register index and data, always ready; write only
//   while no frame is in flight and no result is pending.
// Result: registered on the transfer that carries the final byte.
// Throughput: one byte per cycle while s_ready is high; the byte-wide CRC update
//   and the frame checks are combinational, feeding the frame registers and the
//   result register.
// Reset: frame state returns to its start (CRC 0xFFFF, position 0) and the
//   registers take their defaults; no result is pending.
// Stall: a pending result holds while m_ready is low; s_ready then stays low
//   only until the result is taken, and drops only while a result waits.
// ----------------------------------------------------------------------------
module command_frame_crc_decoder
    import cfcd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input byte stream
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_frame_byte,
    input  logic                   s_frame_end,
    // Result stream
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [2:0]             m_status,
    output logic [7:0]             m_op,
    output logic [15:0]            m_seq_number,
    output logic signed [15:0]     m_left_drive,
    output logic signed [15:0]     m_right_drive,
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg, cfg_next;
    frame_t frame;
    logic   byte_accept;
    logic   result_load;

    // Take a byte whenever the result register is free or being drained
    assign s_ready     = !m_valid || m_ready;
    assign byte_accept = s_valid && s_ready;
    assign result_load = byte_accept && s_frame_end;
    assign cfg_ready   = 1'b1;

    // Register writes; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROTOCOL_VERSION: cfg_next.protocol_version = cfg_data[7:0];
                REG_STOP_CODE:        cfg_next.stop_code        = cfg_data[7:0];
                REG_DRIVE_CODE:       cfg_next.drive_code       = cfg_data[7:0];
                REG_DRIVE_LIMIT:      cfg_next.drive_limit      = cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol_version <= PROTOCOL_VERSION_RST;
            cfg_reg.stop_code        <= STOP_CODE_RST;
            cfg_reg.drive_code       <= DRIVE_CODE_RST;
            cfg_reg.drive_limit      <= DRIVE_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cfcd_capture u_capture (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .byte_accept      (byte_accept),
        .frame_byte       (s_frame_byte),
        .frame_end        (s_frame_end),
        .protocol_version (cfg_reg.protocol_version),
        .frame            (frame)
    );

    cfcd_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .result_load   (result_load),
        .frame_byte    (s_frame_byte),
        .frame         (frame),
        .cfg           (cfg_reg),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_op          (m_op),
        .m_seq_number  (m_seq_number),
        .m_left_drive  (m_left_drive),
        .m_right_drive (m_right_drive)
    );

endmodule

// ===== tb/command_frame_crc_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_frame_crc_decoder_tb
// Feeds byte-wide command frames into the decoder: clean frames with a good
// CRC, frames with a bad version, CRC, opcode, range, stop semantics or
// length, and random noise. Register settings change between phases. Every
// accepted byte goes to a frame model that predicts the result of each frame.
// Every result transfer is checked field by field against the oldest
// prediction. Random stalls on both channels.
// ----------------------------------------------------------------------------
module command_frame_crc_decoder_tb;
    import cfcd_pkg::*;

    // Index that decodes to no register
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 8'hFF;

    typedef struct packed {
        status_t     status;
        logic [7:0]  op;
        logic [15:0] seq_number;
        logic [15:0] left_drive;
        logic [15:0] right_drive;
    } frame_result_t;

    // Frame model: register copies, frame state and the results still owed
    class frame_scoreboard;
        logic [7:0]         version_reg;
        logic [7:0]         stop_reg;
        logic [7:0]         drive_reg;
        logic [14:0]        limit_reg;
        logic [3:0]         pos;
        logic [15:0]        crc;
        logic               version_ok;
        logic [7:0]         op_byte;
        logic [15:0]        seq_word;
        logic signed [15:0] left_word;
        logic signed [15:0] right_word;
        logic [7:0]         crc_low;
        frame_result_t      results_q[$];
        int                 errors;

        function new();
            version_reg = PROTOCOL_VERSION_RST;
            stop_reg    = STOP_CODE_RST;
            drive_reg   = DRIVE_CODE_RST;
            limit_reg   = DRIVE_LIMIT_RST;
            errors      = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos        = '0;
            crc        = CRC_INIT;
            version_ok = 1'b0;
            op_byte    = '0;
            seq_word   = '0;
            left_word  = '0;
            right_word = '0;
            crc_low    = '0;
        endfunction

        // Bit-serial CRC-16/CCITT-FALSE, MSB first
        static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
            logic fb;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ d[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        // Keep only the register's width; ignore unknown indexes
        function void write_reg(logic [7:0] idx, logic [15:0] data);
            case (idx)
                REG_PROTOCOL_VERSION: version_reg = data[7:0];
                REG_STOP_CODE:        stop_reg    = data[7:0];
                REG_DRIVE_CODE:       drive_reg   = data[7:0];
                REG_DRIVE_LIMIT:      limit_reg   = data[14:0];
                default: ;
            endcase
        endfunction

        // Absorb one accepted byte; on the end flag, predict the frame result
        function void note_byte(logic [7:0] b, logic last);
            int lim;
            int l;
            int r;
            frame_result_t res;
            if (pos < CRC_SPAN) begin
                crc = crc_next(crc, b);
            end
            case (pos)
                4'd0: version_ok = (b == version_reg);
                4'd1: op_byte = b;
                4'd2: seq_word[7:0] = b;
                4'd3: seq_word[15:8] = b;
                4'd4: left_word[7:0] = b;
                4'd5: left_word[15:8] = b;
                4'd6: right_word[7:0] = b;
                4'd7: right_word[15:8] = b;
                4'd8: crc_low = b;
                default: ;
            endcase
            if (!last) begin
                if (pos != INDEX_MAX) begin
                    pos++;
                end
                return;
            end
            lim = int'(limit_reg);
            l   = int'(left_word);
            r   = int'(right_word);
            res = '0;
            if (pos != FRAME_LAST_POS) begin
                res.status = STATUS_BAD_LENGTH;
            end else if (!version_ok) begin
                res.status = STATUS_BAD_VERSION;
            end else if ({b, crc_low} != crc) begin
                res.status = STATUS_BAD_CRC;
            end else if (op_byte != stop_reg && op_byte != drive_reg) begin
                res.status = STATUS_BAD_OPCODE;
            end else if (l < -lim || l > lim || r < -lim || r > lim) begin
                res.status = STATUS_BAD_RANGE;
            end else if (op_byte == stop_reg && (l != 0 || r != 0)) begin
                res.status = STATUS_BAD_SEMANTIC;
            end else begin
                res.status      = STATUS_OK;
                res.op          = op_byte;
                res.seq_number  = seq_word;
                res.left_drive  = left_word;
                res.right_drive = right_word;
            end
            results_q.push_back(res);
            clear_frame();
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one result transfer with the oldest prediction
        task check_result(logic [2:0] status, logic [7:0] op, logic [15:0] seq,
                          logic [15:0] left, logic [15:0] right);
            frame_result_t want;
            if (results_q.size() == 0) begin
                report($sformatf("result with status %0d and no frame outstanding",
                                 status));
                return;
            end
            want = results_q.pop_front();
            if (status !== want.status)
                report($sformatf("status got %0d want %0d", status, want.status));
            if (op !== want.op)
                report($sformatf("op got %02h want %02h", op, want.op));
            if (seq !== want.seq_number)
                report($sformatf("seq_number got %04h want %04h", seq, want.seq_number));
            if (left !== want.left_drive)
                report($sformatf("left_drive got %04h want %04h", left, want.left_drive));
            if (right !== want.right_drive)
                report($sformatf("right_drive got %04h want %04h", right,
                                 want.right_drive));
        endtask

        function int pending();
            return results_q.size();
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [7:0]             s_frame_byte;
    logic                   s_frame_end;
    logic                   m_valid;
    logic                   m_ready;
    logic [2:0]             m_status;
    logic [7:0]             m_op;
    logic [15:0]            m_seq_number;
    logic signed [15:0]     m_left_drive;
    logic signed [15:0]     m_right_drive;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bit                     idle_in;
    bit                     idle_out;
    logic [7:0]             frame_bytes[$];
    frame_scoreboard        sb;

    command_frame_crc_decoder u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_frame_end  (s_frame_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_op         (m_op),
        .m_seq_number (m_seq_number),
        .m_left_drive (m_left_drive),
        .m_right_drive(m_right_drive),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_ready <= !(idle_out && $urandom_range(0, 99) < 27);
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_status, m_op, m_seq_number, m_left_drive, m_right_drive);
        end
    end

    // Hard stop for a hung run
    initial begin
        #5_000_000;
        $display("command_frame_crc_decoder_tb: errors");
        $finish;
    end

    // Offer one byte, hold it until the transfer, then note it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_in && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= b;
        s_frame_end  <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, last);
        @(negedge aclk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    // Write one register; the caller drops cfg_valid after the last write
    task automatic write_cfg(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // Lay out a well-formed frame with its CRC appended little-endian
    task automatic build_frame(input logic [7:0] ver, input logic [7:0] op,
                               input logic [15:0] seq, input int l, input int r);
        logic [15:0] crc;
        frame_bytes.delete();
        frame_bytes.push_back(ver);
        frame_bytes.push_back(op);
        frame_bytes.push_back(seq[7:0]);
        frame_bytes.push_back(seq[15:8]);
        frame_bytes.push_back(l[7:0]);
        frame_bytes.push_back(l[15:8]);
        frame_bytes.push_back(r[7:0]);
        frame_bytes.push_back(r[15:8]);
        crc = CRC_INIT;
        foreach (frame_bytes[i]) begin
            crc = frame_scoreboard::crc_next(crc, frame_bytes[i]);
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic trim_frame(input int n);
        while (frame_bytes.size() > n) begin
            void'(frame_bytes.pop_back());
        end
    endtask

    task automatic grow_frame(input int n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    // Drive value near the limit edges, at the 16-bit extremes, or anywhere
    function automatic int pick_drive();
        int lim;
        lim = int'(sb.limit_reg);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return lim;
            2: return -lim;
            3: return lim + 1;
            4: return -lim - 1;
            5: return 32767;
            6: return -32768;
            7: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 2 * lim)) - lim;
        endcase
    endfunction

    // Mostly clean frames under the current settings, the rest damaged
    task automatic rand_frame();
        int          kind;
        int          l;
        int          r;
        logic [7:0]  op;
        logic [7:0]  flip;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            op = sb.stop_reg;
        end else if (kind < 85) begin
            op = sb.drive_reg;
        end else begin
            op = 8'($urandom);
        end
        if (op == sb.stop_reg && $urandom_range(0, 9) < 7) begin
            l = 0;
            r = 0;
        end else begin
            l = pick_drive();
            r = pick_drive();
        end
        build_frame(sb.version_reg, op, 16'($urandom), l, r);
        kind = $urandom_range(0, 99);
        flip = 8'h01 << $urandom_range(0, 7);
        if (kind >= 95) begin
            frame_bytes.delete();
            grow_frame($urandom_range(1, 16));
        end else if (kind >= 90) begin
            grow_frame($urandom_range(1, 10));
        end else if (kind >= 84) begin
            trim_frame($urandom_range(1, 9));
        end else if (kind >= 77) begin
            frame_bytes[$urandom_range(0, 9)] ^= flip;
        end else if (kind >= 70) begin
            frame_bytes[0] ^= 8'($urandom_range(1, 255));
        end
    endtask

    task automatic random_frames(input int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            rand_frame();
            sent += frame_bytes.size();
            send_frame();
        end
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic end_phase();
        int n;
        s_valid <= 1'b0;
        n = 0;
        while (sb.pending() != 0 && n < 5000) begin
            @(negedge aclk);
            n++;
        end
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d frame results never arrived", sb.pending()));
            sb.results_q.delete();
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic random_regs();
        logic [7:0] code;
        write_cfg(REG_PROTOCOL_VERSION, 16'($urandom));
        write_cfg(REG_STOP_CODE, 16'($urandom));
        write_cfg(REG_DRIVE_CODE, 16'($urandom));
        write_cfg(REG_DRIVE_LIMIT, 16'($urandom));
        code = 8'($urandom_range(4, 255));
        write_cfg(code, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] code;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_frame_byte = '0;
        s_frame_end  = 1'b0;
        m_ready      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_PROTOCOL_VERSION;
        cfg_data     = '0;
        idle_in      = 1'b1;
        idle_out     = 1'b1;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset settings: one frame of each kind
        build_frame(8'd1, 8'd1, 16'hFFFF, 1000, -1000);
        send_frame();
        build_frame(8'd1, 8'd0, 16'h0000, 0, 0);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h1234, 5, 6);
        trim_frame(1);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h1234, 5, 6);
        trim_frame(9);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h1234, 5, 6);
        grow_frame(1);
        send_frame();
        // long enough to pin the byte counter at its ceiling
        build_frame(8'd1, 8'd0, 16'h0000, 0, 0);
        grow_frame(10);
        send_frame();
        build_frame(8'd2, 8'd1, 16'h0001, 0, 0);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h0002, 0, 0);
        frame_bytes[9] ^= 8'h80;
        send_frame();
        build_frame(8'd1, 8'd2, 16'h0003, 0, 0);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h0004, 1001, 0);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h0005, 0, -1001);
        send_frame();
        build_frame(8'd1, 8'd0, 16'h0006, 0, 1);
        send_frame();
        build_frame(8'd1, 8'd1, 16'h0007, 32767, -32768);
        send_frame();
        random_frames(150);
        end_phase();

        // Version, stop code and limit at their top, drive code zero; upper data bits set to check masking
        write_cfg(REG_PROTOCOL_VERSION, 16'hFFFF);
        write_cfg(REG_STOP_CODE, 16'h5AFF);
        write_cfg(REG_DRIVE_CODE, 16'hFF00);
        write_cfg(REG_DRIVE_LIMIT, 16'hFFFF);
        write_cfg(REG_NONE, 16'h0001);
        cfg_valid <= 1'b0;
        build_frame(8'hFF, 8'h00, 16'h8000, 32767, -32767);
        send_frame();
        build_frame(8'hFF, 8'hFF, 16'h7FFF, 32767, -32768);
        send_frame();
        random_frames(150);
        end_phase();

        // Zero limit with stop and drive sharing one opcode
        write_cfg(REG_PROTOCOL_VERSION, 16'h0000);
        write_cfg(REG_STOP_CODE, 16'h005A);
        write_cfg(REG_DRIVE_CODE, 16'h005A);
        write_cfg(REG_DRIVE_LIMIT, 16'h0000);
        cfg_valid <= 1'b0;
        build_frame(8'h00, 8'h5A, 16'h00FF, 0, 0);
        send_frame();
        build_frame(8'h00, 8'h5A, 16'hFF00, 1, 0);
        send_frame();
        random_frames(150);
        end_phase();

        // Shared opcode with room in the limit: stop rules apply
        code = 8'($urandom_range(0, 255));
        write_cfg(REG_PROTOCOL_VERSION, 16'($urandom));
        write_cfg(REG_STOP_CODE, {8'h00, code});
        write_cfg(REG_DRIVE_CODE, {8'h00, code});
        write_cfg(REG_DRIVE_LIMIT, 16'($urandom_range(1, 32767)));
        cfg_valid <= 1'b0;
        build_frame(sb.version_reg, code, 16'h0A0A, 0, -1);
        send_frame();
        random_frames(150);
        end_phase();

        // Long stretch at full rate on both sides
        idle_in  = 1'b0;
        idle_out = 1'b0;
        random_regs();
        random_frames(250);
        end_phase();
        idle_in  = 1'b1;
        idle_out = 1'b1;

        random_regs();
        random_frames(150);
        end_phase();

        repeat (8) @(negedge aclk);
        if (sb.errors == 0) begin
            $display("command_frame_crc_decoder_tb: clean");
        end else begin
            $display("command_frame_crc_decoder_tb: errors");
        end
        $finish;
    end

endmodule

// ===== command_frame_crc_decoder.f =====
hw/rtl/cfcd_pkg.sv
hw/rtl/cfcd_capture.sv
hw/rtl/cfcd_check.sv
hw/rtl/command_frame_crc_decoder.sv
tb/command_frame_crc_decoder_tb.sv
